// ===== design/mpc_pkg.sv =====
// Shared types and constants for the Mandelbrot pixel colour unit.
// Used by the register block, controller, datapath and top level.
package mpc_pkg;

	// Largest pixel index; larger coordinates are clamped to it.
	localparam int unsigned IMAGE_SIZE = 1024;
	localparam logic [9:0]  PIX_LAST   = 10'((IMAGE_SIZE > 1024) ? 1023 : IMAGE_SIZE - 1);

	localparam int unsigned FRAC_BITS = 28;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_ORIGIN_REAL  = 3'd0;
	localparam logic [2:0] REG_ORIGIN_IMAG  = 3'd1;
	localparam logic [2:0] REG_PIXEL_PITCH  = 3'd2;
	localparam logic [2:0] REG_ITER_LIMIT   = 3'd3;
	localparam logic [2:0] REG_START_COUNT  = 3'd4;
	localparam logic [2:0] REG_ESCAPE_THR   = 3'd5;

	typedef struct packed {
		logic [31:0] origin_real;
		logic [31:0] origin_imag;
		logic [30:0] pixel_pitch;
		logic [9:0]  iteration_limit;
		logic [9:0]  start_count;
		logic [30:0] escape_threshold;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP,
		ST_CVAL,
		ST_MUL,
		ST_SUM,
		ST_UPD,
		ST_DIV,
		ST_DIV_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;    // take the pixel coordinates
		logic map;        // pixel * pitch products
		logic cval;       // form c, clear z, load count
		logic mul;        // z products
		logic sum;        // squared sum and difference
		logic upd;        // escape decision and z update
		logic div_start;  // start the colour divide
		logic load_out;   // load the output register
	} dp_cmd_t;

	typedef struct packed {
		logic at_limit;
		logic escape;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	// Clamp a wide signed value into a signed field of cw bits.
	function automatic logic signed [63:0] sat_coord(input logic signed [65:0] v,
			input int unsigned cw);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = (66'sd1 <<< (cw - 1)) - 66'sd1;
		lo = -hi - 66'sd1;
		if (v > hi)
			return hi[63:0];
		else if (v < lo)
			return lo[63:0];
		else
			return v[63:0];
	endfunction

endpackage

// ===== design/mpc_cfg_regs.sv =====
// APB-style configuration registers of the Mandelbrot pixel colour unit.
// Depends on mpc_pkg for the register indexes and the cfg_t struct.
module mpc_cfg_regs
	import mpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_real      <= '0;
			cfg_q.origin_imag      <= '0;
			cfg_q.pixel_pitch      <= 31'd2684354;
			cfg_q.iteration_limit  <= 10'd100;
			cfg_q.start_count      <= '0;
			cfg_q.escape_threshold <= 31'd1073741824;
		end else if (wr_en) begin
			unique case (idx)
				REG_ORIGIN_REAL: cfg_q.origin_real      <= pwdata;
				REG_ORIGIN_IMAG: cfg_q.origin_imag      <= pwdata;
				REG_PIXEL_PITCH: cfg_q.pixel_pitch      <= pwdata[30:0];
				REG_ITER_LIMIT:  cfg_q.iteration_limit  <= pwdata[9:0];
				REG_START_COUNT: cfg_q.start_count      <= pwdata[9:0];
				REG_ESCAPE_THR:  cfg_q.escape_threshold <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ORIGIN_REAL: prdata = cfg_q.origin_real;
			REG_ORIGIN_IMAG: prdata = cfg_q.origin_imag;
			REG_PIXEL_PITCH: prdata = {1'b0, cfg_q.pixel_pitch};
			REG_ITER_LIMIT:  prdata = {22'd0, cfg_q.iteration_limit};
			REG_START_COUNT: prdata = {22'd0, cfg_q.start_count};
			REG_ESCAPE_THR:  prdata = {1'b0, cfg_q.escape_threshold};
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== design/mpc_div.sv =====
// Radix-2 restoring divider for the colour value, 8 quotient bits.
// The quotient is known to be below 256. Depends on no other module or package.
module mpc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [17:0] dividend,
	input  logic [9:0]  divisor,
	output logic [7:0]  quotient,
	output logic        done
);

	logic        busy_q;
	logic        done_q;
	logic [2:0]  step_q;
	logic [9:0]  rem_q;
	logic [7:0]  quo_q;
	logic [11:0] trial;
	logic        qbit;

	// remainder stays below the divisor, so the trial fits in 12 bits
	assign trial = {1'b0, rem_q, quo_q[7]} - {2'b00, divisor};
	assign qbit  = !trial[11];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd7;
			end else if (busy_q) begin
				step_q <= step_q - 3'd1;
				if (step_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[17:8];
			quo_q <= dividend[7:0];
		end else if (busy_q) begin
			rem_q <= qbit ? trial[9:0] : {rem_q[8:0], quo_q[7]};
			quo_q <= {quo_q[6:0], qbit};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

`ifndef SYNTHESIS
	a_div_finish: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start && step_q == 3'd0 |=> done_q && !busy_q)
		else $error("divider did not finish after its last step");
`endif

endmodule

// ===== design/mpc_datapath.sv =====
// Datapath: pixel mapping, z = z*z + c iteration, colour divide and output register.
// Depends on mpc_pkg and mpc_div; driven by commands from mpc_ctrl.
module mpc_datapath
	import mpc_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [9:0]  pixel_x,
	input  logic [9:0]  pixel_y,
	output logic        colour_valid,
	input  logic        colour_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        inside_set
);

	localparam int unsigned EW = (COORD_WIDTH > 33) ? COORD_WIDTH : 33;
	localparam logic signed [EW-1:0] BIG_POS = EW'(34'sd2147483648);
	localparam logic signed [EW-1:0] BIG_NEG = -BIG_POS;

	logic [9:0]                    px_q, py_q;
	logic [40:0]                   map_r_q, map_i_q;
	logic signed [COORD_WIDTH-1:0] cr_q, ci_q, zr_q, zi_q;
	logic [9:0]                    count_q;
	logic signed [63:0]            prod_xx_q, prod_yy_q, prod_xy_q;
	logic                          big_q;
	logic [63:0]                   sq_sum_q;
	logic signed [35:0]            re_q;
	logic signed [36:0]            im_q;
	logic                          inside_q;
	logic                          colour_valid_q;
	logic [7:0]                    red_q, green_q, blue_q;
	logic                          inside_set_q;

	logic signed [EW-1:0] zr_ext, zi_ext;
	logic signed [31:0]   mr, mi;
	logic                 big;
	logic signed [63:0]   diff;
	logic signed [65:0]   cr_sum, ci_sum, zr_sum, zi_sum;
	logic signed [63:0]   cr_sat, ci_sat, zr_sat, zi_sat;
	logic                 escape;
	logic                 at_limit;
	logic [17:0]          dividend;
	logic [7:0]           quo;
	logic                 div_done;
	logic [15:0]          g_prod;
	logic                 out_free;

	assign zr_ext = EW'(zr_q);
	assign zi_ext = EW'(zi_q);
	// Only the low 32 bits matter: a larger component has escaped anyway.
	assign mr     = zr_ext[31:0];
	assign mi     = zi_ext[31:0];
	assign big    = zr_ext >= BIG_POS || zr_ext <= BIG_NEG
		|| zi_ext >= BIG_POS || zi_ext <= BIG_NEG;

	assign diff   = prod_xx_q - prod_yy_q;

	assign cr_sum = 66'($signed(cfg.origin_real)) + 66'($signed({1'b0, map_r_q}));
	assign ci_sum = 66'($signed(cfg.origin_imag)) + 66'($signed({1'b0, map_i_q}));
	assign zr_sum = 66'(re_q) + 66'(cr_q);
	assign zi_sum = 66'(im_q) + 66'(ci_q);
	assign cr_sat = sat_coord(cr_sum, COORD_WIDTH);
	assign ci_sat = sat_coord(ci_sum, COORD_WIDTH);
	assign zr_sat = sat_coord(zr_sum, COORD_WIDTH);
	assign zi_sat = sat_coord(zi_sum, COORD_WIDTH);

	assign escape   = big_q || (sq_sum_q[63:FRAC_BITS] > 36'(cfg.escape_threshold));
	assign at_limit = count_q >= cfg.iteration_limit;

	// 255 * count
	assign dividend = {count_q, 8'd0} - {8'd0, count_q};

	// v / 3 for v < 256 as (v * 171) >> 9
	assign g_prod   = {8'd0, quo} * 16'd171;
	assign out_free = !colour_valid_q || !colour_stall;

	mpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (cfg.iteration_limit),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q <= (pixel_x > PIX_LAST) ? PIX_LAST : pixel_x;
			py_q <= (pixel_y > PIX_LAST) ? PIX_LAST : pixel_y;
		end
		if (cmd.map) begin
			map_r_q <= {31'd0, px_q} * {10'd0, cfg.pixel_pitch};
			map_i_q <= {31'd0, py_q} * {10'd0, cfg.pixel_pitch};
		end
		if (cmd.cval) begin
			cr_q    <= cr_sat[COORD_WIDTH-1:0];
			ci_q    <= ci_sat[COORD_WIDTH-1:0];
			zr_q    <= '0;
			zi_q    <= '0;
			count_q <= cfg.start_count;
		end
		if (cmd.mul) begin
			prod_xx_q <= mr * mr;
			prod_yy_q <= mi * mi;
			prod_xy_q <= mr * mi;
			big_q     <= big;
		end
		if (cmd.sum) begin
			sq_sum_q <= prod_xx_q + prod_yy_q;
			re_q     <= diff[63:FRAC_BITS];
			im_q     <= prod_xy_q[63:FRAC_BITS-1];
		end
		if (cmd.upd) begin
			inside_q <= at_limit;
			if (!at_limit && !escape) begin
				zr_q    <= zr_sat[COORD_WIDTH-1:0];
				zi_q    <= zi_sat[COORD_WIDTH-1:0];
				count_q <= count_q + 10'd1;
			end
		end
		if (cmd.load_out) begin
			red_q        <= inside_q ? 8'd0 : quo;
			blue_q       <= inside_q ? 8'd0 : quo;
			green_q      <= inside_q ? 8'd0 : {1'b0, g_prod[15:9]};
			inside_set_q <= inside_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			colour_valid_q <= 1'b0;
		else if (cmd.load_out)
			colour_valid_q <= 1'b1;
		else if (!colour_stall)
			colour_valid_q <= 1'b0;
	end

	assign stat.at_limit = at_limit;
	assign stat.escape   = escape;
	assign stat.div_done = div_done;
	assign stat.out_free = out_free;

	assign colour_valid = colour_valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign inside_set   = inside_set_q;

`ifndef SYNTHESIS
	a_inside_black: assert property (@(posedge clk) disable iff (!arst_n)
		colour_valid_q && inside_set_q |-> red_q == 8'd0 && green_q == 8'd0 && blue_q == 8'd0)
		else $error("pixel inside the set is not black");

	a_blue_red: assert property (@(posedge clk) disable iff (!arst_n)
		colour_valid_q |-> blue_q == red_q)
		else $error("blue differs from red");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd && !at_limit && !escape |=> count_q <= cfg.iteration_limit)
		else $error("iteration count ran past the limit");
`endif

endmodule

// ===== design/mpc_ctrl.sv =====
// Controller state machine: sequences pixel mapping, iteration, divide and output.
// Depends on mpc_pkg for state_t and the command/status structs.
module mpc_ctrl
	import mpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pixel_valid,
	output logic     pixel_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (pixel_valid) state_d = ST_MAP;
			ST_MAP:      state_d = ST_CVAL;
			ST_CVAL:     state_d = ST_MUL;
			ST_MUL:      state_d = ST_SUM;
			ST_SUM:      state_d = ST_UPD;
			ST_UPD: begin
				priority if (stat.at_limit)
					state_d = ST_DONE;
				else if (stat.escape)
					state_d = ST_DIV;
				else
					state_d = ST_MUL;
			end
			ST_DIV:      state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (stat.div_done) state_d = ST_DONE;
			ST_DONE:     if (stat.out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		pixel_stall   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				pixel_stall = 1'b0;
				cmd.capture = pixel_valid;
			end
			ST_MAP:      cmd.map       = 1'b1;
			ST_CVAL:     cmd.cval      = 1'b1;
			ST_MUL:      cmd.mul       = 1'b1;
			ST_SUM:      cmd.sum       = 1'b1;
			ST_UPD:      cmd.upd       = 1'b1;
			ST_DIV:      cmd.div_start = 1'b1;
			ST_DIV_WAIT: ;
			ST_DONE:     cmd.load_out  = stat.out_free;
			default:     ;
		endcase
	end

`ifndef SYNTHESIS
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> state_q == ST_DIV_WAIT)
		else $error("divide finished outside its wait state");

	a_accept_map: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall |=> state_q == ST_MAP)
		else $error("accepted pixel did not start mapping");
`endif

endmodule

// ===== design/mandelbrot_pixel_colour_unit.sv =====
// Mandelbrot escape-time pixel colour unit, top level.
// Instantiates mpc_cfg_regs, mpc_ctrl and mpc_datapath; uses mpc_pkg.
//
// Usage:
//  - Pixel channel (pixel_valid / pixel_stall, pixel_x, pixel_y): one
//    transaction per pixel. The unit works on one pixel at a time and holds
//    pixel_stall high from acceptance until the pixel's colour has been
//    loaded into the output register.
//  - Colour channel (colour_valid / colour_stall, red, green, blue,
//    inside_set): one transaction per pixel, from an output register, so a
//    new pixel is taken while a finished colour waits to be taken. While
//    colour_stall is high the output holds and a second finished pixel
//    waits in the datapath.
//  - Timing: each iteration of z = z*z + c runs through the multiply,
//    sum and update states via the shared product registers. An
//    escaped pixel then runs the 8-step colour divide; a pixel inside
//    the set goes straight to the output. pixel_stall falls in the same
//    cycle as colour_valid rises.
//  - Configuration is to be written through the APB-style port while
//    idle; the unit itself does not enforce this.
//  - Reset (arst_n low) returns the registers to their defaults, empties
//    the output register and puts the controller in idle.
module mandelbrot_pixel_colour_unit
	import mpc_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [9:0]  pixel_x,
	input  logic [9:0]  pixel_y,
	output logic        colour_valid,
	input  logic        colour_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        inside_set
);

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	mpc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mpc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	mpc_datapath #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.stat         (stat),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.colour_valid (colour_valid),
		.colour_stall (colour_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.inside_set   (inside_set)
	);

endmodule

// ===== dv/tb_mandelbrot_pixel_colour_unit.sv =====
// Testbench for mandelbrot_pixel_colour_unit: drives pixels and APB register writes,
// predicts every color and checks it field by field against the colour channel.
// Depends on design/mpc_pkg.sv and the unit's RTL.
`timescale 1ns / 1ps

module tb_mandelbrot_pixel_colour_unit
	import mpc_pkg::*;
();

	localparam longint COORD_HI        = 64'sd2147483647;
	localparam longint COORD_LO        = -64'sd2147483648;
	localparam int     WATCHDOG_LIMIT  = 20000;
	localparam int     PRINT_CAP       = 25;

	// classic full-set view: corner (-2.0, -1.5), 3/1024 per pixel
	localparam logic [31:0] CLASSIC_REAL  = 32'hE000_0000;
	localparam logic [31:0] CLASSIC_IMAG  = 32'hE800_0000;
	localparam logic [31:0] CLASSIC_PITCH = 32'h000C_0000;

	localparam logic [31:0] DEFAULT_PITCH = 32'd2684354;
	localparam logic [31:0] THR_FOUR      = 32'h4000_0000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       in_set;
	} colour_t;

	typedef struct {
		logic [9:0] px;
		logic [9:0] py;
		colour_t    colour;
	} pixel_colour_t;

	typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BLOCKS} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        pixel_valid = 1'b0;
	logic        pixel_stall;
	logic [9:0]  pixel_x = '0;
	logic [9:0]  pixel_y = '0;
	logic        colour_valid;
	logic        colour_stall = 1'b0;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        inside_set;

	// shadow of the register file
	longint      view_real = 0;
	longint      view_imag = 0;
	longint      pitch = 2684354;
	longint      escape_thr = 1073741824;
	int unsigned iter_limit = 100;
	int unsigned first_count = 0;

	pixel_colour_t expected_colours[$];
	int            mismatches = 0;
	int            pixels_sent = 0;
	int            settings_used = 0;
	int            escaped_seen = 0;
	int            inside_seen = 0;
	int            burst_left = 0;
	int            quiet_cycles = 0;
	int            rx_cycle = 0;
	rx_mode_t      rx_mode = RX_OPEN;

	mandelbrot_pixel_colour_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.colour_valid(colour_valid), .colour_stall(colour_stall),
		.red(red), .green(green), .blue(blue), .inside_set(inside_set)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint clamp_coord(input longint v);
		if (v > COORD_HI)
			return COORD_HI;
		if (v < COORD_LO)
			return COORD_LO;
		return v;
	endfunction

	function automatic bit has_escaped(input longint x, input longint y);
		longint ax;
		longint ay;
		longint mag;
		// a component at the saturation floor counts as escaped outright
		if (x > COORD_HI || x <= COORD_LO || y > COORD_HI || y <= COORD_LO)
			return 1'b1;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		mag = (ax * ax + ay * ay) >>> FRAC_BITS;
		return mag > escape_thr;
	endfunction

	function automatic colour_t predict_colour(input logic [9:0] px, input logic [9:0] py);
		longint      cr;
		longint      ci;
		longint      zr;
		longint      zi;
		longint      re;
		longint      im;
		int unsigned count;
		int unsigned shade;
		colour_t     c;
		cr = clamp_coord(view_real + longint'(px) * pitch);
		ci = clamp_coord(view_imag + longint'(py) * pitch);
		zr = 0;
		zi = 0;
		count = first_count;
		while (count < iter_limit && !has_escaped(zr, zi)) begin
			re = (zr * zr - zi * zi) >>> FRAC_BITS;
			im = (zr * zi) >>> (FRAC_BITS - 1);
			zr = clamp_coord(re + cr);
			zi = clamp_coord(im + ci);
			count++;
		end
		if (count < iter_limit) begin
			shade = (255 * count) / iter_limit;
			c.red = shade[7:0];
			c.green = 8'(shade / 3);
			c.blue = shade[7:0];
			c.in_set = 1'b0;
		end else begin
			c = '0;
			c.in_set = 1'b1;
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what, input logic [9:0] px, input logic [9:0] py,
			input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] MISMATCH %s pixel (%0d,%0d): got %0h want %0h",
				$realtime, what, px, py, got, want);
	endtask

	task automatic check_colour();
		pixel_colour_t want;
		if (expected_colours.size() == 0) begin
			report_mismatch("colour with nothing pending", '0, '0, 32'({red, green, blue}), '0);
			return;
		end
		want = expected_colours.pop_front();
		if (red !== want.colour.red)
			report_mismatch("red", want.px, want.py, 32'(red), 32'(want.colour.red));
		if (green !== want.colour.green)
			report_mismatch("green", want.px, want.py, 32'(green), 32'(want.colour.green));
		if (blue !== want.colour.blue)
			report_mismatch("blue", want.px, want.py, 32'(blue), 32'(want.colour.blue));
		if (inside_set !== want.colour.in_set)
			report_mismatch("inside_set", want.px, want.py, 32'(inside_set),
				32'(want.colour.in_set));
	endtask

	// colour receiver with a stall pattern that is changed at random
	always @(posedge clk) begin
		if (arst_n && colour_valid && !colour_stall)
			check_colour();
		rx_cycle++;
		if (rx_cycle % 200 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:   colour_stall <= 1'b0;
			RX_LIGHT:  colour_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY:  colour_stall <= ($urandom_range(0, 3) != 0);
			default:   colour_stall <= ((rx_cycle % 50) < 30);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (pixel_valid && !pixel_stall) || (colour_valid && !colour_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ORIGIN_REAL: view_real = longint'($signed(value));
			REG_ORIGIN_IMAG: view_imag = longint'($signed(value));
			REG_PIXEL_PITCH: pitch = longint'(value[30:0]);
			REG_ITER_LIMIT:  iter_limit = 32'(value[9:0]);
			REG_START_COUNT: first_count = 32'(value[9:0]);
			REG_ESCAPE_THR:  escape_thr = longint'(value[30:0]);
			default: ;
		endcase
	endtask

	task automatic set_view(input logic [31:0] re, input logic [31:0] im, input logic [31:0] step);
		write_reg(REG_ORIGIN_REAL, re);
		write_reg(REG_ORIGIN_IMAG, im);
		write_reg(REG_PIXEL_PITCH, step);
	endtask

	// valid is only dropped in a gap between bursts or at the end of a phase
	task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
		pixel_colour_t item;
		if (burst_left == 0) begin
			pixel_valid <= 1'b0;
			pixel_x <= 10'($urandom());
			pixel_y <= 10'($urandom());
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
		pixel_valid <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		do @(posedge clk); while (pixel_stall !== 1'b0);
		burst_left--;
		item.px = x;
		item.py = y;
		item.colour = predict_colour(x, y);
		expected_colours = {expected_colours, item};
		pixels_sent++;
		if (item.colour.in_set)
			inside_seen++;
		else
			escaped_seen++;
	endtask

	task automatic send_random_pixels(input int n);
		for (int i = 0; i < n; i++)
			send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
	endtask

	// idle only once every pending color has come back
	task automatic end_phase();
		pixel_valid <= 1'b0;
		while (expected_colours.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		settings_used++;
	endtask

	task automatic test_directed_corners();
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd0, 10'd1023);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd1, 10'd1);
		send_pixel(10'd200, 10'd0);
		send_pixel(10'h2AA, 10'h155);
		send_pixel(10'h155, 10'h2AA);
		end_phase();
	endtask

	task automatic test_start_vs_limit();
		write_reg(REG_START_COUNT, 32'd100);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		end_phase();
		write_reg(REG_START_COUNT, 32'd1023);
		send_pixel(10'd512, 10'd3);
		end_phase();
		// zero limit: black, no divide
		write_reg(REG_ITER_LIMIT, 32'd0);
		write_reg(REG_START_COUNT, 32'd0);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		end_phase();
		write_reg(REG_ITER_LIMIT, 32'd1);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd0, 10'd0);
		end_phase();
		// high offset gives the brightest escaped colors
		write_reg(REG_ITER_LIMIT, 32'd1023);
		write_reg(REG_START_COUNT, 32'd1020);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		end_phase();
	endtask

	task automatic test_saturation_and_threshold();
		set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		write_reg(REG_ITER_LIMIT, 32'd10);
		write_reg(REG_START_COUNT, 32'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd0);
		end_phase();
		write_reg(REG_ESCAPE_THR, 32'h7FFF_FFFF);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd0, 10'd1023);
		end_phase();
		// bit 31 is outside the register, so this is a zero threshold
		set_view(32'd0, 32'd0, DEFAULT_PITCH);
		write_reg(REG_ESCAPE_THR, 32'h8000_0000);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1, 10'd0);
		end_phase();
	endtask

	task automatic test_default_view();
		set_view(32'd0, 32'd0, DEFAULT_PITCH);
		write_reg(REG_ITER_LIMIT, 32'd100);
		write_reg(REG_START_COUNT, 32'd0);
		write_reg(REG_ESCAPE_THR, THR_FOUR);
		send_random_pixels(150);
		end_phase();
	endtask

	task automatic test_classic_view();
		set_view(CLASSIC_REAL, CLASSIC_IMAG, CLASSIC_PITCH);
		write_reg(REG_ITER_LIMIT, 32'd32);
		write_reg(REG_START_COUNT, 32'd0);
		send_random_pixels(250);
		end_phase();
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_ITER_LIMIT, $urandom_range(8, 48));
			write_reg(REG_START_COUNT, $urandom_range(0, 4));
			send_random_pixels(50);
			end_phase();
		end
	endtask

	task automatic test_zoomed_views();
		logic [31:0] thr;
		for (int p = 0; p < 6; p++) begin
			set_view($urandom_range(0, 671088640) - 536870912,
				$urandom_range(0, 671088640) - 335544320,
				$urandom_range(1, 1 << 20));
			write_reg(REG_ITER_LIMIT, $urandom_range(16, 96));
			write_reg(REG_START_COUNT, $urandom_range(0, 3));
			thr = (p % 2 == 0) ? THR_FOUR : $urandom_range(32'h1000_0000, 32'h7FFF_FFFF);
			write_reg(REG_ESCAPE_THR, thr);
			send_random_pixels(50);
			end_phase();
		end
	endtask

	// noise: random register values, junk above the narrow fields
	task automatic test_random_registers();
		for (int p = 0; p < 6; p++) begin
			set_view($urandom(), $urandom(), $urandom());
			write_reg(REG_ITER_LIMIT, {22'($urandom()), 10'($urandom_range(0, 48))});
			write_reg(REG_START_COUNT, {22'($urandom()), 10'($urandom_range(0, 56))});
			write_reg(REG_ESCAPE_THR, $urandom());
			send_random_pixels(40);
			end_phase();
		end
	endtask

	task automatic test_deep_limit();
		set_view(CLASSIC_REAL, CLASSIC_IMAG, CLASSIC_PITCH);
		write_reg(REG_ESCAPE_THR, THR_FOUR);
		write_reg(REG_ITER_LIMIT, 32'd1023);
		write_reg(REG_START_COUNT, 32'd0);
		send_pixel(10'd682, 10'd512);
		send_pixel(10'd600, 10'd512);
		send_pixel(10'd400, 10'd600);
		send_random_pixels(3);
		end_phase();
		write_reg(REG_START_COUNT, $urandom_range(990, 1022));
		send_random_pixels(6);
		end_phase();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_start_vs_limit();
		test_saturation_and_threshold();
		test_default_view();
		test_classic_view();
		test_zoomed_views();
		test_random_registers();
		test_deep_limit();
		repeat (30) @(posedge clk);
		if (expected_colours.size() != 0)
			report_mismatch("colours never returned", '0, '0, '0,
				32'(expected_colours.size()));
		$display("covered %0d pixels over %0d register settings", pixels_sent, settings_used);
		$display("predicted %0d escaped and %0d inside the set", escaped_seen, inside_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
design/mpc_pkg.sv
design/mpc_cfg_regs.sv
design/mpc_div.sv
design/mpc_datapath.sv
design/mpc_ctrl.sv
design/mandelbrot_pixel_colour_unit.sv
dv/tb_mandelbrot_pixel_colour_unit.sv
